/* rtl/core/hgf_pkg.sv */
// shared types, constants and helpers of the horizontal gradient filter
package hgf_pkg;

    // default for the largest supported row length
    localparam int MAX_WIDTH_DEF = 4096;

    // configuration register file
    localparam int          CFG_ADDR_W       = 3;
    localparam int          IMG_W_BITS       = 13;
    localparam logic [0:0]  REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // one pixel: red in [7:0], green in [15:8], blue in [23:16]
    localparam int PIX_W = 24;

    // work for the back end: one or two results
    typedef struct packed {
        logic             ends;     // pixel closes its row, second result follows
        logic [PIX_W-1:0] center;   // pending pixel, left neighbor of the row-end result
        logic [PIX_W-1:0] left;     // left neighbor of the pending pixel
        logic [PIX_W-1:0] right;    // new pixel, right neighbor of the pending pixel
    } cmd_t;

    // absolute difference of two channel values, never above 255
    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/core/hgf_fifo.sv */
// short command queue between front and back
module hgf_fifo import hgf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/hgf_front.sv */
// input side: pixel window, column tracking and command issue
module hgf_front import hgf_pkg::*; #(
    parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW        = $clog2(MAX_WIDTH),
    localparam int WW        = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,
    input  logic [WW-1:0]    last_col,
    input  logic             q_full,
    output logic             push,
    output cmd_t             push_cmd
);

    logic [CW-1:0]    col_reg, col_next;
    logic [PIX_W-1:0] left_reg, left_next;
    logic [PIX_W-1:0] center_reg, center_next;
    logic             beat;
    logic             row_first;
    logic             ends;

    assign s_tready  = !q_full;
    assign beat      = s_tvalid && s_tready;
    assign row_first = (col_reg == '0);
    assign ends      = (WW'(col_reg) >= last_col);

    // first pixel of a row only loads the window
    assign push            = beat && !row_first;
    assign push_cmd.ends   = ends;
    assign push_cmd.center = center_reg;
    assign push_cmd.left   = left_reg;
    assign push_cmd.right  = s_tdata;

    // window and column update
    always_comb begin
        col_next    = col_reg;
        left_next   = left_reg;
        center_next = center_reg;
        if (beat) begin
            if (row_first) begin
                left_next   = '0;
                center_next = s_tdata;
                col_next    = CW'(1);
            end else if (ends) begin
                left_next   = '0;
                center_next = '0;
                col_next    = '0;
            end else begin
                left_next   = center_reg;
                center_next = s_tdata;
                col_next    = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            left_reg   <= '0;
            center_reg <= '0;
        end else begin
            col_reg    <= col_next;
            left_reg   <= left_next;
            center_reg <= center_next;
        end
    end

endmodule

/* rtl/core/hgf_back.sv */
// output side: difference per channel into the output register
module hgf_back import hgf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             head_cmd,
    input  logic             q_empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    logic             valid_reg, valid_next;
    logic             second_reg, second_next;
    logic [PIX_W-1:0] data_reg, data_next;
    logic             row_end_reg, row_end_next;
    logic             run_last_reg, run_last_next;
    logic             load;
    logic [PIX_W-1:0] grad;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = row_end_reg;
    assign m_tuser  = run_last_reg;

    // output register free when empty or being taken
    assign load = !q_empty && (!valid_reg || m_tready);
    assign pop  = load && (second_reg || !head_cmd.ends);

    // per channel difference; row-end result has zero as right neighbor
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (second_reg) begin
                grad[8*c +: 8] = head_cmd.center[8*c +: 8];
            end else begin
                grad[8*c +: 8] = absdiff8(head_cmd.right[8*c +: 8], head_cmd.left[8*c +: 8]);
            end
        end
    end

    always_comb begin
        valid_next    = valid_reg;
        second_next   = second_reg;
        data_next     = data_reg;
        row_end_next  = row_end_reg;
        run_last_next = run_last_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next    = 1'b1;
            data_next     = grad;
            row_end_next  = second_reg;
            run_last_next = second_reg || !head_cmd.ends;
            second_next   = !second_reg && head_cmd.ends;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        data_reg     <= data_next;
        row_end_reg  <= row_end_next;
        run_last_reg <= run_last_next;
    end

endmodule

/* rtl/core/horizontal_gradient_filter_top.sv */
// top level of the horizontal gradient filter with its register port
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: red [7:0], green [15:8], blue [23:16]
//  m_        out  m_tvalid/m_tready  m_tdata: grad r/g/b, m_tlast row end, m_tuser run end
//  apb       in   psel/penable       image_width at byte address 0
//
//  one pixel beat per clock while the queue is not full; a result passes the queue, then the output register, to m_
//  the last pixel of a row gives the back end two results; a four entry queue absorbs it
//  s_tready drops only when the queue is full, m_tready low stalls the back end alone
//  aresetn is synchronous, clears window, column, queue and output valid
module horizontal_gradient_filter_top import hgf_pkg::*; #(
    parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW        = $clog2(MAX_WIDTH),
    localparam int WW        = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // grad_red, grad_green, grad_blue
    output logic                  m_tlast,   // row_end
    output logic                  m_tuser,   // last_of_run
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [IMG_W_BITS-1:0] img_w_reg, img_w_next;
    logic [WW-1:0]         last_col_reg, last_col_next;
    logic                  cfg_wr;
    logic                  push;
    cmd_t                  push_cmd;
    logic                  pop;
    cmd_t                  head_cmd;
    logic                  q_full;
    logic                  q_empty;

    // clamp the row length to 2..MAX_WIDTH and return the last column
    function automatic logic [WW-1:0] last_col_of(input logic [IMG_W_BITS-1:0] w);
        logic [WW-1:0] e;
        e = WW'(w);
        if (e < WW'(2)) begin
            e = WW'(2);
        end
        if (e > WW'(MAX_WIDTH)) begin
            e = WW'(MAX_WIDTH);
        end
        return e - WW'(1);
    endfunction

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IMAGE_WIDTH);
    assign prdata = (paddr[2] == REG_IMAGE_WIDTH) ? 32'(img_w_reg) : '0;

    always_comb begin
        img_w_next    = img_w_reg;
        last_col_next = last_col_reg;
        if (cfg_wr) begin
            img_w_next    = pwdata[IMG_W_BITS-1:0];
            last_col_next = last_col_of(pwdata[IMG_W_BITS-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg    <= IMAGE_WIDTH_RST;
            last_col_reg <= last_col_of(IMAGE_WIDTH_RST);
        end else begin
            img_w_reg    <= img_w_next;
            last_col_reg <= last_col_next;
        end
    end

    hgf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .last_col (last_col_reg),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    hgf_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    hgf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/core/hgf_checker.sv */
// port level checks of the horizontal gradient filter, bound to the top level
module hgf_checker import hgf_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [PIX_W-1:0]      m_tdata,
    input logic                  m_tlast,
    input logic                  m_tuser,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [31:0]           pwdata,
    input logic [31:0]           prdata,
    input logic                  pready
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // reset leaves the queue empty, so input is ready
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // a row-end result always closes its pixel's run
    a_row_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("row end without run end");

    // the width register reads back what was written
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && !paddr[2]
            |=> paddr[2] || (prdata[12:0] == $past(pwdata[12:0])))
        else $error("image width readback mismatch");

endmodule

bind horizontal_gradient_filter_top hgf_checker u_hgf_checker (.*);

/* tb/sv/tb.sv */
// self-checking testbench of the horizontal gradient filter: pixel stream in, gradients checked
module tb;
    import hgf_pkg::*;

    localparam int MAX_W          = MAX_WIDTH_DEF;
    localparam int IDLE_LIMIT     = 2000;
    localparam int RANDOM_PIXELS  = 1550;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [CFG_ADDR_W-1:0] WIDTH_ADDR = CFG_ADDR_W'(4 * REG_IMAGE_WIDTH);

    // pixel and gradient as they sit on the data buses, lowest field last
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic       run_end;
        logic       row_end;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } grad_t;

    // typed-in results for a pixel; count below zero means use the predictor
    typedef struct {
        int    count;
        grad_t first;
        grad_t second;
    } hint_t;

    typedef struct {
        bit          is_cfg;
        logic [31:0] value;
        int          count;
        grad_t       first;
        grad_t       second;
    } stim_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata  = '0;   // red_in, green_in, blue_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIX_W-1:0]      m_tdata;         // grad_red, grad_green, grad_blue
    logic                  m_tlast;         // row_end
    logic                  m_tuser;         // last_of_run
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor state
    logic [12:0] width_reg  = IMAGE_WIDTH_RST;
    rgb_t        win_left   = '0;
    rgb_t        win_center = '0;
    logic [11:0] col_cnt    = '0;

    grad_t pending_grads[$];
    hint_t pixel_hints[$];
    int    fail_count  = 0;
    int    idle_cycles = 0;
    bit    tx_burst    = 1'b0;
    bit    rx_burst    = 1'b0;

    horizontal_gradient_filter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    function automatic grad_t grad_lit(int r, int g, int b, bit row_end, bit run_end);
        grad_t res;
        res.red     = r[7:0];
        res.green   = g[7:0];
        res.blue    = b[7:0];
        res.row_end = row_end;
        res.run_end = run_end;
        return res;
    endfunction

    // per channel |right - left|; two 8-bit values never differ by more than 255
    function automatic grad_t gradient_of(rgb_t right, rgb_t left, logic row_end, logic run_end);
        grad_t res;
        res.red     = (right.red > left.red) ? right.red - left.red : left.red - right.red;
        res.green   = (right.green > left.green) ? right.green - left.green
                                                 : left.green - right.green;
        res.blue    = (right.blue > left.blue) ? right.blue - left.blue : left.blue - right.blue;
        res.row_end = row_end;
        res.run_end = run_end;
        return res;
    endfunction

    // slide the two-pixel window by one pixel and give the gradients it completes
    task automatic advance_window(input rgb_t px, output int n, output grad_t r0,
                                  output grad_t r1);
        int   eff;
        logic ends;
        eff  = (width_reg < 2) ? 2 : (width_reg > MAX_W) ? MAX_W : int'(width_reg);
        ends = (col_cnt >= eff - 1);
        n    = 0;
        r0   = '0;
        r1   = '0;
        if (col_cnt == 0) begin
            // first pixel of a row only loads the window
            win_left   = '0;
            win_center = px;
            col_cnt    = 1;
        end else begin
            r0 = gradient_of(px, win_left, 1'b0, !ends);
            n  = 1;
            if (ends) begin
                // row end: the right border is zero padded
                r1         = gradient_of('0, win_center, 1'b1, 1'b1);
                n          = 2;
                win_left   = '0;
                win_center = '0;
                col_cnt    = '0;
            end else begin
                win_left   = win_center;
                win_center = px;
                col_cnt    = col_cnt + 1'b1;
            end
        end
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // beat monitor: compare results, predict on every accepted pixel
    always @(posedge aclk) begin
        grad_t want;
        grad_t r0;
        grad_t r1;
        hint_t hint;
        int    n;
        if (aresetn) begin
            // results first: a pixel taken at this edge cannot have its results out yet
            if (m_tvalid && m_tready) begin
                if (pending_grads.size() == 0) begin
                    $error("result beat with no result expected: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_grads.pop_front();
                    check_field("grad_red", want.red, m_tdata[7:0]);
                    check_field("grad_green", want.green, m_tdata[15:8]);
                    check_field("grad_blue", want.blue, m_tdata[23:16]);
                    check_field("row_end", want.row_end, m_tlast);
                    check_field("last_of_run", want.run_end, m_tuser);
                end
            end
            if (s_tvalid && s_tready) begin
                hint = pixel_hints.pop_front();
                advance_window(s_tdata, n, r0, r1);
                if (hint.count >= 0) begin
                    n  = hint.count;
                    r0 = hint.first;
                    r1 = hint.second;
                end
                if (n > 0) pending_grads.insert(pending_grads.size(), r0);
                if (n > 1) pending_grads.insert(pending_grads.size(), r1);
            end
        end
    end

    // watchdog on cycles without any beat or register access
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side: random stall before each beat, none in burst stretches
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic logic [7:0] rand_chan();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input rgb_t px, input hint_t hint, input int gap);
        pixel_hints.insert(pixel_hints.size(), hint);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // hold off the sender until every result is out, then let the pipe settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_grads.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write, then read back
    task automatic write_width(input logic [31:0] value);
        drain_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= WIDTH_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        width_reg = value[12:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {19'b0, value[12:0]}) begin
            $error("image_width: expected %0d, got %0d", value[12:0], prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stimulus
    initial begin
        stim_row_t rows[$];
        hint_t     hint;
        int        specials[$];
        int        w;
        int        eff;
        int        count;
        int        random_pixels;
        rgb_t      px;

        random_pixels = 0;
        // directed rows; the first pixels run at the reset width
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'h000000, 0, '0, '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'hffffff, 1,
                                             grad_lit(255, 255, 255, 0, 1), '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'h000000, 1,
                                             grad_lit(0, 0, 0, 0, 1), '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'hff00ff, 1,
                                             grad_lit(0, 255, 0, 0, 1), '0});
        // narrow width mid-row, junk in the upper write bits: next pixel closes the row
        rows.insert(rows.size(), stim_row_t'{1'b1, 32'hffffe002, -1, '0, '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'h563412, -1, '0, '0});
        // width zero is taken as two
        rows.insert(rows.size(), stim_row_t'{1'b1, 32'd0, -1, '0, '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'hffffff, 0, '0, '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'h00ff00, 2,
                                             grad_lit(0, 255, 0, 0, 0),
                                             grad_lit(255, 255, 255, 1, 1)});
        // width one is taken as two
        rows.insert(rows.size(), stim_row_t'{1'b1, 32'd1, -1, '0, '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'h808080, 0, '0, '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'h7f017f, -1, '0, '0});
        rows.insert(rows.size(), stim_row_t'{1'b1, 32'd3, -1, '0, '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'h0000ff, 0, '0, '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'hff0000, -1, '0, '0});
        rows.insert(rows.size(), stim_row_t'{1'b0, 32'h010101, -1, '0, '0});

        // reset
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                write_width(rows[i].value);
            end else begin
                hint = '{rows[i].count, rows[i].first, rows[i].second};
                send_pixel(rows[i].value[23:0], hint, $urandom_range(0, 7));
            end
        end

        // random phases, each at its own width; a phase may stop mid-row
        specials = '{4097, 5, 8191, 2, 640, 1, 4096, 7, 0, 3, 16};
        hint = '{-1, '0, '0};
        while (random_pixels < RANDOM_PIXELS) begin
            if (specials.size() != 0) w = specials.pop_front();
            else if ($urandom_range(0, 4) == 0) w = $urandom_range(0, 3);
            else w = $urandom_range(2, 24);
            if ($urandom_range(0, 1) == 0) write_width(w);
            else write_width(($urandom() & ~32'h1fff) | w);
            eff = (w < 2) ? 2 : (w > MAX_W) ? MAX_W : w;
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if (eff == MAX_W) count = $urandom_range(8, 20);
            else if (eff > 64) count = eff + $urandom_range(1, 10);
            else count = eff * $urandom_range(1, 5) + $urandom_range(0, eff - 1);
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(0, 99) == 0) drain_results();
                px.red   = rand_chan();
                px.green = rand_chan();
                px.blue  = rand_chan();
                send_pixel(px, hint, tx_burst ? 0 : $urandom_range(0, 7));
            end
            random_pixels += count;
        end

        // wind down
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_grads.size() != 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* horizontal_gradient_filter_top.f */
rtl/core/hgf_pkg.sv
rtl/core/hgf_fifo.sv
rtl/core/hgf_front.sv
rtl/core/hgf_back.sv
rtl/core/horizontal_gradient_filter_top.sv
rtl/core/hgf_checker.sv
tb/sv/tb.sv
